[rtl/quaternion_rotate_vector_macros.svh]
// ----------------------------------------------------------------------------
// Quaternion rotate vector assertion macros
// Shared concurrent assertion forms used by the rotation block.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_ROTATE_VECTOR_MACROS_SVH
`define QUATERNION_ROTATE_VECTOR_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define QRV_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("quaternion_rotate_vector: assertion failed");

// Next-cycle implication, checked while out of reset.
`define QRV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("quaternion_rotate_vector: assertion failed");

`endif

[rtl/qrv_pkg.sv]
// ----------------------------------------------------------------------------
// Quaternion rotate vector package
// Widths, payload types and the final round and saturate function.
// ----------------------------------------------------------------------------
package qrv_pkg;

  localparam int QW        = 16;  // component width of quaternion and vector
  localparam int PW        = 2 * QW;  // width of a first-half product
  localparam int MW        = PW + 1;  // width of a first-half sum
  localparam int FW        = QW + MW; // width of a second-half product
  localparam int SW        = 52;  // width of a final exact sum
  localparam int RND_SHIFT = 28;  // scale of a final sum
  localparam int RW        = SW - RND_SHIFT;

  localparam logic signed [SW-1:0] RND_BIAS = SW'(64'sd1 <<< (RND_SHIFT - 1));
  localparam logic signed [RW-1:0] SAT_MAX  = RW'(32'sd32767);
  localparam logic signed [RW-1:0] SAT_MIN  = RW'(-32'sd32768);

  typedef struct packed {
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
    logic signed [QW-1:0] w;
  } quat_t;

  typedef struct packed {
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
  } vec_t;

  // Intermediate quaternion: d is the dot product (the negated scalar part).
  typedef struct packed {
    logic signed [MW-1:0] d;
    logic signed [MW-1:0] ux;
    logic signed [MW-1:0] uy;
    logic signed [MW-1:0] uz;
  } mid_t;

  // Final exact sums with the rounding bias already added.
  typedef struct packed {
    logic signed [SW-1:0] x;
    logic signed [SW-1:0] y;
    logic signed [SW-1:0] z;
  } wide_t;

  typedef struct packed {
    logic signed [QW-1:0] val;
    logic                 sat;
  } sat_t;

  // Floor shift of a biased sum, then clip to the 16-bit range.
  function automatic sat_t round_sat(input logic signed [SW-1:0] t);
    logic signed [RW-1:0] q;
    sat_t                 r;
    q = RW'(t >>> RND_SHIFT);
    if (q > SAT_MAX) begin
      r.val = QW'(SAT_MAX);
      r.sat = 1'b1;
    end else if (q < SAT_MIN) begin
      r.val = QW'(SAT_MIN);
      r.sat = 1'b1;
    end else begin
      r.val = QW'(q);
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

[rtl/qrv_vecmul.sv]
// ----------------------------------------------------------------------------
// Quaternion times pure vector
// Two stages: twelve 16x16 products, then the dot and cross sums.
// ----------------------------------------------------------------------------
module qrv_vecmul (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  qrv_pkg::quat_t in_quat,
  input  qrv_pkg::vec_t  in_vec,
  output logic           out_valid,
  input  logic           out_stall,
  output qrv_pkg::quat_t out_quat,
  output qrv_pkg::mid_t  out_mid
);

  logic v1;
  logic v2;
  logic adv1;
  logic adv2;

  qrv_pkg::quat_t quat1;
  logic signed [qrv_pkg::PW-1:0] xx, yy, zz;
  logic signed [qrv_pkg::PW-1:0] wx, yz, zy;
  logic signed [qrv_pkg::PW-1:0] wy, zx, xz;
  logic signed [qrv_pkg::PW-1:0] wz, xy, yx;

  assign adv2     = !v2 || !out_stall;
  assign adv1     = !v1 || adv2;
  assign in_stall = !adv1;
  assign out_valid = v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= in_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      quat1 <= in_quat;
      xx <= in_quat.x * in_vec.x;
      yy <= in_quat.y * in_vec.y;
      zz <= in_quat.z * in_vec.z;
      wx <= in_quat.w * in_vec.x;
      yz <= in_quat.y * in_vec.z;
      zy <= in_quat.z * in_vec.y;
      wy <= in_quat.w * in_vec.y;
      zx <= in_quat.z * in_vec.x;
      xz <= in_quat.x * in_vec.z;
      wz <= in_quat.w * in_vec.z;
      xy <= in_quat.x * in_vec.y;
      yx <= in_quat.y * in_vec.x;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      out_quat   <= quat1;
      out_mid.d  <= qrv_pkg::MW'(xx) + qrv_pkg::MW'(yy) + qrv_pkg::MW'(zz);
      out_mid.ux <= qrv_pkg::MW'(wx) + qrv_pkg::MW'(yz) - qrv_pkg::MW'(zy);
      out_mid.uy <= qrv_pkg::MW'(wy) + qrv_pkg::MW'(zx) - qrv_pkg::MW'(xz);
      out_mid.uz <= qrv_pkg::MW'(wz) + qrv_pkg::MW'(xy) - qrv_pkg::MW'(yx);
    end
  end

endmodule

[rtl/qrv_conjmul.sv]
// ----------------------------------------------------------------------------
// Intermediate times conjugate
// Two stages: twelve 16x33 products, then the biased vector-part sums.
// ----------------------------------------------------------------------------
module qrv_conjmul (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  qrv_pkg::quat_t in_quat,
  input  qrv_pkg::mid_t  in_mid,
  output logic           out_valid,
  input  logic           out_stall,
  output qrv_pkg::wide_t out_sum
);

  logic v1;
  logic v2;
  logic adv1;
  logic adv2;

  // With d = -s, the term s*(-q) becomes d*q.
  logic signed [qrv_pkg::FW-1:0] wux, dqx, uzqy, uyqz;
  logic signed [qrv_pkg::FW-1:0] wuy, dqy, uxqz, uzqx;
  logic signed [qrv_pkg::FW-1:0] wuz, dqz, uyqx, uxqy;

  assign adv2      = !v2 || !out_stall;
  assign adv1      = !v1 || adv2;
  assign in_stall  = !adv1;
  assign out_valid = v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= in_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      wux  <= in_quat.w * in_mid.ux;
      dqx  <= in_quat.x * in_mid.d;
      uzqy <= in_quat.y * in_mid.uz;
      uyqz <= in_quat.z * in_mid.uy;
      wuy  <= in_quat.w * in_mid.uy;
      dqy  <= in_quat.y * in_mid.d;
      uxqz <= in_quat.z * in_mid.ux;
      uzqx <= in_quat.x * in_mid.uz;
      wuz  <= in_quat.w * in_mid.uz;
      dqz  <= in_quat.z * in_mid.d;
      uyqx <= in_quat.x * in_mid.uy;
      uxqy <= in_quat.y * in_mid.ux;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      out_sum.x <= qrv_pkg::SW'(wux) + qrv_pkg::SW'(dqx) + qrv_pkg::SW'(uzqy)
                   - qrv_pkg::SW'(uyqz) + qrv_pkg::RND_BIAS;
      out_sum.y <= qrv_pkg::SW'(wuy) + qrv_pkg::SW'(dqy) + qrv_pkg::SW'(uxqz)
                   - qrv_pkg::SW'(uzqx) + qrv_pkg::RND_BIAS;
      out_sum.z <= qrv_pkg::SW'(wuz) + qrv_pkg::SW'(dqz) + qrv_pkg::SW'(uyqx)
                   - qrv_pkg::SW'(uxqy) + qrv_pkg::RND_BIAS;
    end
  end

endmodule

[rtl/qrv_sat.sv]
// ----------------------------------------------------------------------------
// Round and saturate output stage
// Shifts the biased sums down, clips them, and holds the result register.
// ----------------------------------------------------------------------------
module qrv_sat (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  qrv_pkg::wide_t              in_sum,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [qrv_pkg::QW-1:0] out_x,
  output logic signed [qrv_pkg::QW-1:0] out_y,
  output logic signed [qrv_pkg::QW-1:0] out_z,
  output logic                        out_sat
);

  logic          v;
  logic          adv;
  qrv_pkg::sat_t sx, sy, sz;

  assign adv       = !v || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = v;

  always_comb begin
    sx = qrv_pkg::round_sat(in_sum.x);
    sy = qrv_pkg::round_sat(in_sum.y);
    sz = qrv_pkg::round_sat(in_sum.z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (adv) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      out_x   <= sx.val;
      out_y   <= sy.val;
      out_z   <= sz.val;
      out_sat <= sx.sat | sy.sat | sz.sat;
    end
  end

endmodule

[rtl/quaternion_rotate_vector.sv]
// A request goes through product and sum registers twice, then a shift-and-clip register.
// Throughput: one request per cycle while the output is not stalled.
// Each stage advances on its own, so bubbles close up while the output is stalled.
// Reset clears only the stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// Quaternion rotate vector
// Rotates a 3D vector by a Q1.14 quaternion as q * v * conj(q), with one
// rounding at the end and 16-bit saturation of each component.
// ----------------------------------------------------------------------------
`include "quaternion_rotate_vector_macros.svh"

module quaternion_rotate_vector (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] vec_x,
  input  logic signed [15:0] vec_y,
  input  logic signed [15:0] vec_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [15:0] rot_x,
  output logic signed [15:0] rot_y,
  output logic signed [15:0] rot_z,
  output logic        saturated
);

  // The datapath is three pieces joined by valid/stall pairs:
  //  1. q * (v, 0): products, then the dot product d and the vector part u.
  //     The scalar part of that intermediate is -d; it is never formed.
  //  2. (-d, u) * conj(q): products, then w*u + d*q.xyz + u x q.xyz terms,
  //     plus half an output LSB so the final shift rounds to nearest.
  //  3. An arithmetic shift by 28 bits, clipping to 16 bits, and the result
  //     register that the consumer sees.
  // All sums before the shift are exact, so the only rounding is the last one.

  qrv_pkg::quat_t quat_in;
  qrv_pkg::vec_t  vec_in;
  qrv_pkg::quat_t mid_quat;
  qrv_pkg::mid_t  mid;
  qrv_pkg::wide_t sum;
  logic           mid_valid;
  logic           mid_stall;
  logic           sum_valid;
  logic           sum_stall;

  assign quat_in = '{x: quat_x, y: quat_y, z: quat_z, w: quat_w};
  assign vec_in  = '{x: vec_x, y: vec_y, z: vec_z};

  qrv_vecmul u_vecmul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_quat   (quat_in),
    .in_vec    (vec_in),
    .out_valid (mid_valid),
    .out_stall (mid_stall),
    .out_quat  (mid_quat),
    .out_mid   (mid)
  );

  qrv_conjmul u_conjmul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .in_stall  (mid_stall),
    .in_quat   (mid_quat),
    .in_mid    (mid),
    .out_valid (sum_valid),
    .out_stall (sum_stall),
    .out_sum   (sum)
  );

  qrv_sat u_sat (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sum_valid),
    .in_stall  (sum_stall),
    .in_sum    (sum),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (rot_x),
    .out_y     (rot_y),
    .out_z     (rot_z),
    .out_sat   (saturated)
  );

  // The input is held back only when every stage is full behind a stalled output.
  `QRV_ASSERT_NOW(a_stall_only_when_full, clk, rst, in_stall,
    out_valid && out_stall && sum_valid && mid_valid)

  // A flagged result has at least one component pinned to a rail.
  `QRV_ASSERT_NOW(a_sat_at_rail, clk, rst, out_valid && saturated,
    rot_x == 16'sh7fff || rot_x == -16'sh8000 || rot_y == 16'sh7fff ||
    rot_y == -16'sh8000 || rot_z == 16'sh7fff || rot_z == -16'sh8000)

  // A result that is taken while the middle is empty leaves the output empty.
  `QRV_ASSERT_NEXT(a_drain, clk, rst, out_valid && !out_stall && !sum_valid,
    !out_valid)

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// Quaternion rotate vector testbench
// Sends quaternion and vector requests through the valid/stall input channel
// and checks every rotated result against typed values or a predictor of
// q * v * conj(q). A short table of hand-picked requests comes first, then
// random ones, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;

  // Run size and pacing.
  localparam int N_DIRECTED     = 20;
  localparam int N_RANDOM       = 2000;
  localparam int N_ITEMS        = N_DIRECTED + N_RANDOM;
  localparam int IDLE_PERCENT   = 22;
  // Requests numbered in this window go through with no idling on either side.
  localparam int QUIET_FIRST    = 900;
  localparam int QUIET_LAST     = 1200;
  localparam int WATCHDOG_LIMIT = 2000;
  // The pipeline is five stages deep; wait well past that at the end.
  localparam int DRAIN_CYCLES   = 20;
  localparam int RESET_CYCLES   = 11;

  // How a table row is checked: against values typed into the row, or
  // against the predictor.
  localparam int CHECK_MODEL = 0;
  localparam int CHECK_TYPED = 1;

  // Columns of the directed table.
  localparam int COL_QX = 0;
  localparam int COL_QY = 1;
  localparam int COL_QZ = 2;
  localparam int COL_QW = 3;
  localparam int COL_VX = 4;
  localparam int COL_VY = 5;
  localparam int COL_VZ = 6;
  localparam int COL_CHECK = 7;
  localparam int COL_RX = 8;
  localparam int COL_RY = 9;
  localparam int COL_RZ = 10;
  localparam int COL_SAT = 11;

  // Random component flavors: near-unit quaternion parts, any 16-bit value,
  // or one of the corner values below.
  typedef enum int {MIX_UNIT, MIX_FULL, MIX_CORNER} mix_t;
  localparam int UNIT_SPAN = 11585;  // about 0.707 in Q1.14
  localparam int CORNER_VALUES [8] = '{-32768, -32767, -16384, -1, 0, 1, 16384, 32767};

  // The directed table. Each row holds quaternion x, y, z, w, vector x, y, z,
  // the check mode, and for typed rows the expected rot_x, rot_y, rot_z and
  // saturated flag.
  localparam int DIRECTED_ROWS [N_DIRECTED][12] = '{
    // Zero quaternion wipes out even the largest vectors.
    '{0, 0, 0, 0, 32767, 32767, 32767, CHECK_TYPED, 0, 0, 0, 0},
    '{0, 0, 0, 0, -32768, -32768, -32768, CHECK_TYPED, 0, 0, 0, 0},
    // Identity, both signs of w: the vector comes back unchanged.
    '{0, 0, 0, 16384, 32767, -32768, 1, CHECK_TYPED, 32767, -32768, 1, 0},
    '{0, 0, 0, -16384, -5, 1234, -32768, CHECK_TYPED, -5, 1234, -32768, 0},
    // Half turns about each axis; negating -32768 has to saturate.
    '{16384, 0, 0, 0, 100, -32768, 7, CHECK_TYPED, 100, 32767, -7, 1},
    '{0, 16384, 0, 0, -32768, 5, 9, CHECK_TYPED, 32767, 5, -9, 1},
    '{0, 0, 16384, 0, 3, -4, -32768, CHECK_TYPED, -3, 4, -32768, 0},
    // Non-unit quaternion of almost 2.0: the result scales by nearly 4.
    '{0, 0, 0, 32767, 32767, 32767, 32767, CHECK_TYPED, 32767, 32767, 32767, 1},
    '{0, 0, 0, 32767, -32768, -32768, -32768, CHECK_TYPED, -32768, -32768, -32768, 1},
    // A component of exactly -2.0 scales by 4, landing right on the limits.
    '{0, 0, 0, -32768, 8191, -8192, 0, CHECK_TYPED, 32764, -32768, 0, 0},
    '{-32768, 0, 0, 0, 1, 1, 1, CHECK_TYPED, 4, -4, -4, 0},
    // w = 0.5 scales by a quarter: ties round up, others to nearest.
    '{0, 0, 0, 8192, 2, -2, 6, CHECK_TYPED, 1, 0, 2, 0},
    '{0, 0, 0, 8192, -3, 32767, -32768, CHECK_TYPED, -1, 8192, -8192, 0},
    '{0, 0, 0, 8192, 1, -1, 3, CHECK_TYPED, 0, 0, 1, 0},
    // Quarter turn about z and a third of a turn about the diagonal.
    '{0, 0, 11585, 11585, 1000, 0, 0, CHECK_MODEL, 0, 0, 0, 0},
    '{8192, 8192, 8192, 8192, 100, 200, 300, CHECK_MODEL, 0, 0, 0, 0},
    // Corners of every field at once.
    '{-32768, -32768, -32768, -32768, 32767, 32767, 32767, CHECK_MODEL, 0, 0, 0, 0},
    '{32767, 32767, 32767, 32767, -32768, -32768, -32768, CHECK_MODEL, 0, 0, 0, 0},
    '{32767, -32768, 32767, -32768, 32767, -32768, 32767, CHECK_MODEL, 0, 0, 0, 0},
    '{1, -1, 1, -1, 32767, -32768, -1, CHECK_MODEL, 0, 0, 0, 0}
  };

  typedef struct packed {
    logic signed [qrv_pkg::QW-1:0] x;
    logic signed [qrv_pkg::QW-1:0] y;
    logic signed [qrv_pkg::QW-1:0] z;
    logic                          sat;
  } rot_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [qrv_pkg::QW-1:0] quat_x = '0;
  logic signed [qrv_pkg::QW-1:0] quat_y = '0;
  logic signed [qrv_pkg::QW-1:0] quat_z = '0;
  logic signed [qrv_pkg::QW-1:0] quat_w = '0;
  logic signed [qrv_pkg::QW-1:0] vec_x = '0;
  logic signed [qrv_pkg::QW-1:0] vec_y = '0;
  logic signed [qrv_pkg::QW-1:0] vec_z = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [qrv_pkg::QW-1:0] rot_x;
  logic signed [qrv_pkg::QW-1:0] rot_y;
  logic signed [qrv_pkg::QW-1:0] rot_z;
  logic                          saturated;

  // Rotations still owed by the block, oldest first.
  rot_result_t pending_rotations[$];

  // Request under construction and the rotation it is expected to produce.
  qrv_pkg::quat_t next_quat;
  qrv_pkg::vec_t  next_vec;
  rot_result_t    loaded_rotation;
  rot_result_t    owed_rotation;
  mix_t           next_mix;

  int requests_issued = 0;
  int requests_accepted = 0;
  int results_seen = 0;
  int mismatches = 0;
  int cycles_without_progress = 0;
  bit timed_out = 1'b0;

  quaternion_rotate_vector DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .quat_x    (quat_x),
    .quat_y    (quat_y),
    .quat_z    (quat_z),
    .quat_w    (quat_w),
    .vec_x     (vec_x),
    .vec_y     (vec_y),
    .vec_z     (vec_z),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rot_x     (rot_x),
    .rot_y     (rot_y),
    .rot_z     (rot_z),
    .saturated (saturated)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Rounds a sum held at a scale of 2^28 to the nearest integer, ties going
  // up, and clips it to 16 bits. Any clipping sets the flag, which is never
  // cleared here so that all three components share it.
  function automatic logic signed [qrv_pkg::QW-1:0] round_and_clip(input longint sum,
                                                                   inout logic sat);
    longint rounded;
    rounded = (sum + (64'sd1 <<< 27)) >>> 28;
    if (rounded > 32767) begin
      sat = 1'b1;
      return qrv_pkg::QW'(32767);
    end else if (rounded < -32768) begin
      sat = 1'b1;
      return qrv_pkg::QW'(-32768);
    end
    return qrv_pkg::QW'(rounded);
  endfunction

  // Predicts the rotated vector. The first product p = q * (v, 0) has the
  // scalar part -dot and the vector part u; the second multiplies p by the
  // conjugate of q, whose vector part is -q.xyz, so the signs fold in below.
  // Everything stays exact in 64 bits until the final rounding.
  function automatic rot_result_t rotate_expected(input qrv_pkg::quat_t q,
                                                  input qrv_pkg::vec_t v);
    longint qx, qy, qz, qw, vx, vy, vz;
    longint dot, ux, uy, uz;
    longint sum_x, sum_y, sum_z;
    rot_result_t r;
    qx = q.x;
    qy = q.y;
    qz = q.z;
    qw = q.w;
    vx = v.x;
    vy = v.y;
    vz = v.z;
    dot = qx * vx + qy * vy + qz * vz;
    ux = qw * vx + qy * vz - qz * vy;
    uy = qw * vy + qz * vx - qx * vz;
    uz = qw * vz + qx * vy - qy * vx;
    sum_x = qw * ux + dot * qx + uz * qy - uy * qz;
    sum_y = qw * uy + dot * qy + ux * qz - uz * qx;
    sum_z = qw * uz + dot * qz + uy * qx - ux * qy;
    r.sat = 1'b0;
    r.x = round_and_clip(sum_x, r.sat);
    r.y = round_and_clip(sum_y, r.sat);
    r.z = round_and_clip(sum_z, r.sat);
    return r;
  endfunction

  function automatic logic signed [qrv_pkg::QW-1:0] random_component(input mix_t mix);
    case (mix)
      MIX_UNIT: begin
        return qrv_pkg::QW'(int'($urandom_range(2 * UNIT_SPAN)) - UNIT_SPAN);
      end
      MIX_CORNER: begin
        return qrv_pkg::QW'(CORNER_VALUES[$urandom_range(7)]);
      end
      default: begin
        return qrv_pkg::QW'($urandom);
      end
    endcase
  endfunction

  function automatic bit take_a_break(input int position);
    if (position >= QUIET_FIRST && position < QUIET_LAST) begin
      return 1'b0;
    end
    return $urandom_range(99) < IDLE_PERCENT;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Request side. A request counts once valid is high and stall is low at a
  // rising edge; its expected rotation is queued at that moment. A stalled
  // request is held untouched. Otherwise the next request is loaded, or the
  // channel goes idle at random.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_rotations.push_back(loaded_rotation);
        requests_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (requests_issued < N_ITEMS && !take_a_break(requests_issued)) begin
          if (requests_issued < N_DIRECTED) begin
            next_quat.x = qrv_pkg::QW'(DIRECTED_ROWS[requests_issued][COL_QX]);
            next_quat.y = qrv_pkg::QW'(DIRECTED_ROWS[requests_issued][COL_QY]);
            next_quat.z = qrv_pkg::QW'(DIRECTED_ROWS[requests_issued][COL_QZ]);
            next_quat.w = qrv_pkg::QW'(DIRECTED_ROWS[requests_issued][COL_QW]);
            next_vec.x = qrv_pkg::QW'(DIRECTED_ROWS[requests_issued][COL_VX]);
            next_vec.y = qrv_pkg::QW'(DIRECTED_ROWS[requests_issued][COL_VY]);
            next_vec.z = qrv_pkg::QW'(DIRECTED_ROWS[requests_issued][COL_VZ]);
            if (DIRECTED_ROWS[requests_issued][COL_CHECK] == CHECK_TYPED) begin
              loaded_rotation.x = qrv_pkg::QW'(DIRECTED_ROWS[requests_issued][COL_RX]);
              loaded_rotation.y = qrv_pkg::QW'(DIRECTED_ROWS[requests_issued][COL_RY]);
              loaded_rotation.z = qrv_pkg::QW'(DIRECTED_ROWS[requests_issued][COL_RZ]);
              loaded_rotation.sat = DIRECTED_ROWS[requests_issued][COL_SAT] != 0;
            end else begin
              loaded_rotation = rotate_expected(next_quat, next_vec);
            end
          end else begin
            // Half the random requests use near-unit quaternions, which give
            // true rotations that mostly stay in range; the rest use any
            // value or the corners, where saturation is common.
            case ($urandom_range(9))
              0, 1, 2, 3, 4: next_mix = MIX_UNIT;
              5, 6, 7:       next_mix = MIX_FULL;
              default:       next_mix = MIX_CORNER;
            endcase
            next_quat.x = random_component(next_mix);
            next_quat.y = random_component(next_mix);
            next_quat.z = random_component(next_mix);
            next_quat.w = random_component(next_mix);
            if (next_mix != MIX_CORNER) begin
              next_mix = MIX_FULL;
            end
            next_vec.x = random_component(next_mix);
            next_vec.y = random_component(next_mix);
            next_vec.z = random_component(next_mix);
            loaded_rotation = rotate_expected(next_quat, next_vec);
          end
          quat_x <= next_quat.x;
          quat_y <= next_quat.y;
          quat_z <= next_quat.z;
          quat_w <= next_quat.w;
          vec_x <= next_vec.x;
          vec_y <= next_vec.y;
          vec_z <= next_vec.z;
          in_valid <= 1'b1;
          requests_issued++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side. Every accepted result is matched against the oldest owed
  // rotation, field by field. Stall is raised at random between results.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_rotations.size() == 0) begin
          $display("%0t: result with no request outstanding: x %0d, y %0d, z %0d, sat %0b",
                   $time, rot_x, rot_y, rot_z, saturated);
          mismatches++;
        end else begin
          owed_rotation = pending_rotations.pop_front();
          check_field("rot_x", owed_rotation.x, rot_x);
          check_field("rot_y", owed_rotation.y, rot_y);
          check_field("rot_z", owed_rotation.z, rot_z);
          check_field("saturated", owed_rotation.sat, saturated);
        end
        results_seen++;
      end
      out_stall <= take_a_break(results_seen);
    end
  end

  // Counts cycles in which neither channel moves anything.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      cycles_without_progress <= 0;
    end else begin
      cycles_without_progress <= cycles_without_progress + 1;
    end
  end

  // Reset once, then wait for every owed rotation to arrive and a little
  // longer to catch stray results, unless the watchdog fires first.
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    fork
      begin
        while (!(requests_accepted == N_ITEMS && pending_rotations.size() == 0)) begin
          @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
      end
      begin
        while (cycles_without_progress < WATCHDOG_LIMIT) begin
          @(posedge clk);
        end
        timed_out = 1'b1;
      end
    join_any
    if (!timed_out && mismatches == 0 && pending_rotations.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
